// ===== rtl/lcc_pkg.sv =====
// Shared constants and codes for the largest connected component block.
// No dependencies; the channel interfaces and the top level import this package.
package lcc_pkg;

  localparam int VTX_W            = 10;
  localparam int SIZE_W           = 11;
  localparam int MAX_VERTICES_DEF = 1024;

  localparam logic FUNC_EDGE   = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_FIND_A = 6'b000100,
    ST_FIND_B = 6'b001000,
    ST_SIZE_A = 6'b010000,
    ST_SIZE_B = 6'b100000
  } lcc_state_e;

endpackage

// ===== rtl/lcc_in_if.sv =====
// Edge and finish item channel of the largest connected component block.
// Depends on lcc_pkg for the field widths.
interface lcc_in_if import lcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [VTX_W-1:0] vertex_a;
  logic [VTX_W-1:0] vertex_b;

  modport source (output valid, func, vertex_a, vertex_b, input ready);
  modport sink   (input valid, func, vertex_a, vertex_b, output ready);
endinterface

// ===== rtl/lcc_out_if.sv =====
// Result channel of the largest connected component block.
// Depends on lcc_pkg for the field widths.
interface lcc_out_if import lcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] largest_size;
  logic              bad_edge_seen;

  modport source (output valid, largest_size, bad_edge_seen, input ready);
  modport sink   (input valid, largest_size, bad_edge_seen, output ready);
endinterface

// ===== rtl/lcc_cfg_if.sv =====
// Configuration write channel carrying the vertex count register.
// Depends on lcc_pkg for the field width.
interface lcc_cfg_if import lcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] vertex_count;

  modport source (output valid, vertex_count, input ready);
  modport sink   (input valid, vertex_count, output ready);
endinterface

// ===== rtl/lcc_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module lcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/largest_component_size_top.sv =====
// Top level of the largest connected component block: union-find sequencer.
// Depends on lcc_pkg, the three channel interfaces and lcc_ram.
//
// Channel   Modport  Direction  Payload
// cfg_i     sink     in         vertex_count
// item_i    sink     in         func, vertex_a, vertex_b
// result_o  source   out        largest_size, bad_edge_seen
//
// An edge walks from each end to its root, one parent hop per cycle through the registered read
// of the parent table; union by size keeps the hop count within log2(MAX_VERTICES). If the roots
// differ, the edge reads both root sizes and hangs the smaller root under the larger; else it
// returns to idle. A rejected edge only sets the bad edge flag. A finish transaction loads the
// result register, then a clearing pass rewrites both tables; the same pass runs after reset.
// No item is taken during that pass or while an untaken result sits in the result register.
module largest_component_size_top import lcc_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lcc_cfg_if.sink   cfg_i,
  lcc_in_if.sink    item_i,
  lcc_out_if.source result_o
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int SW = $clog2(MAX_VERTICES + 1);
  localparam int CW = (SW > SIZE_W) ? SW : SIZE_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_VERTICES - 1);

  lcc_state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [AW-1:0] vb_q, vb_d;
  logic [AW-1:0] ra_q, ra_d;
  logic [AW-1:0] rb_q, rb_d;
  logic [SW-1:0] sa_q, sa_d;
  logic [SW-1:0] largest_q, largest_d;
  logic bad_q, bad_d;
  logic [SIZE_W-1:0] vc_q;
  logic out_valid_q, out_valid_d;
  logic [SIZE_W-1:0] out_size_q;
  logic out_bad_q;

  logic p_we;
  logic [AW-1:0] p_waddr, p_wdata, p_rdata;
  logic s_we;
  logic [AW-1:0] s_waddr, s_raddr;
  logic [SW-1:0] s_wdata, s_rdata;

  logic item_acc, fin_acc, in_range, swap_w;
  logic [CW-1:0] n_eff;
  logic [SW-1:0] sum_w;

  assign cfg_i.ready  = 1'b1;
  assign item_i.ready = (state_q == ST_IDLE) && (!out_valid_q || result_o.ready);
  assign item_acc     = item_i.valid && item_i.ready;
  assign fin_acc      = item_acc && (item_i.func == FUNC_FINISH);

  always_comb begin
    if (vc_q == '0) begin
      n_eff = CW'(1);
    end else if (CW'(vc_q) > CW'(MAX_VERTICES)) begin
      n_eff = CW'(MAX_VERTICES);
    end else begin
      n_eff = CW'(vc_q);
    end
  end

  assign in_range = (CW'(item_i.vertex_a) < n_eff) && (CW'(item_i.vertex_b) < n_eff);
  assign swap_w   = sa_q < s_rdata;
  assign sum_w    = sa_q + s_rdata;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cur_d     = cur_q;
    vb_d      = vb_q;
    ra_d      = ra_q;
    rb_d      = rb_q;
    sa_d      = sa_q;
    largest_d = largest_q;
    bad_d     = bad_q;
    p_we      = 1'b0;
    p_waddr   = clr_q;
    p_wdata   = clr_q;
    s_we      = 1'b0;
    s_waddr   = clr_q;
    s_wdata   = SW'(1);
    s_raddr   = ra_q;
    case (state_q)
      ST_CLEAR: begin
        p_we = 1'b1;
        s_we = 1'b1;
        if (clr_q == LAST_IDX) begin
          clr_d   = '0;
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (item_acc) begin
          if (item_i.func == FUNC_FINISH) begin
            largest_d = SW'(1);
            bad_d     = 1'b0;
            state_d   = ST_CLEAR;
          end else if (!in_range) begin
            bad_d = 1'b1;
          end else begin
            cur_d   = AW'(item_i.vertex_a);
            vb_d    = AW'(item_i.vertex_b);
            state_d = ST_FIND_A;
          end
        end
      end
      ST_FIND_A: begin
        if (p_rdata == cur_q) begin
          ra_d    = cur_q;
          cur_d   = vb_q;
          state_d = ST_FIND_B;
        end else begin
          cur_d = p_rdata;
        end
      end
      ST_FIND_B: begin
        if (p_rdata == cur_q) begin
          rb_d    = cur_q;
          state_d = (cur_q == ra_q) ? ST_IDLE : ST_SIZE_A;
        end else begin
          cur_d = p_rdata;
        end
      end
      ST_SIZE_A: begin
        sa_d    = s_rdata;
        s_raddr = rb_q;
        state_d = ST_SIZE_B;
      end
      ST_SIZE_B: begin
        p_we    = 1'b1;
        p_waddr = swap_w ? ra_q : rb_q;
        p_wdata = swap_w ? rb_q : ra_q;
        s_we    = 1'b1;
        s_waddr = swap_w ? rb_q : ra_q;
        s_wdata = sum_w;
        if (sum_w > largest_q) begin
          largest_d = sum_w;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  always_comb begin
    if (fin_acc) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      largest_q   <= SW'(1);
      bad_q       <= 1'b0;
      vc_q        <= SIZE_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      largest_q   <= largest_d;
      bad_q       <= bad_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        vc_q <= cfg_i.vertex_count;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    vb_q  <= vb_d;
    ra_q  <= ra_d;
    rb_q  <= rb_d;
    sa_q  <= sa_d;
    if (fin_acc) begin
      out_size_q <= SIZE_W'(largest_q);
      out_bad_q  <= bad_q;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.largest_size  = out_size_q;
  assign result_o.bad_edge_seen = out_bad_q;

  lcc_ram #(
    .WIDTH(AW),
    .DEPTH(MAX_VERTICES)
  ) u_parent_ram (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(p_waddr),
    .wdata_i(p_wdata),
    .raddr_i(cur_d),
    .rdata_o(p_rdata)
  );

  lcc_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_VERTICES)
  ) u_size_ram (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(s_waddr),
    .wdata_i(s_wdata),
    .raddr_i(s_raddr),
    .rdata_o(s_rdata)
  );

`ifndef SYNTHESIS
  a_finish_starts_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_acc |=> (state_q == ST_CLEAR) && out_valid_q)
    else $error("finish transaction did not start the clearing pass");

  a_merge_distinct_roots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SIZE_B) |-> (ra_q != rb_q))
    else $error("merge of a component with itself");

  a_largest_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SIZE_B) |=> (largest_q >= $past(largest_q)))
    else $error("largest size shrank on a merge");

  a_largest_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (largest_q != '0) && (largest_q <= SW'(MAX_VERTICES)))
    else $error("largest size out of bounds");

  a_clear_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) && (clr_q == LAST_IDX) |=> (state_q == ST_IDLE))
    else $error("clearing pass did not end at the last entry");
`endif

endmodule
